@@ rtl/lgta_pkg.sv @@
// Shared types and constants for the lexis grid time accumulator.
// Holds the port beat structs, the internal chain item and the code enums.
// No dependencies.
package lgta_pkg;

    localparam int SIGMA_CELLS_DEF = 4;
    localparam int TAU_CELLS_DEF   = 4;
    localparam int TOTAL_WIDTH_DEF = 48;
    localparam int TIME_W          = 32;
    localparam int OUT_W           = 48;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_READ = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NOP  = 2'd0,
        OP_LOAD = 2'd1,
        OP_ADD  = 2'd2,
        OP_READ = 2'd3
    } t_op;

    typedef struct packed {
        t_action             action;
        logic                axis;
        logic [2:0]          edge_index;
        logic [TIME_W-1:0]   edge_value;
        logic [TIME_W-1:0]   start_sigma;
        logic [TIME_W-1:0]   start_tau;
        logic [TIME_W-1:0]   duration;
        logic [1:0]          cell_row;
        logic [1:0]          cell_col;
    } t_in_beat;

    typedef struct packed {
        t_status             status;
        logic [OUT_W-1:0]    cell_total;
    } t_out_beat;

    // One item as it travels down the cell chain.
    typedef struct packed {
        logic                valid;
        t_op                 op;
        t_status             status;
        logic                axis;
        logic [2:0]          edge_index;
        logic [TIME_W-1:0]   edge_value;
        logic [TIME_W-1:0]   s;
        logic [TIME_W-1:0]   t;
        logic [TIME_W-1:0]   d;
        logic [1:0]          row;
        logic [1:0]          col;
        logic [OUT_W-1:0]    total;
    } t_item;

endpackage

@@ rtl/lgta_head.sv @@
// Entry stage of the accumulator: decodes a beat, checks the segment end
// points against the outer grid edges and launches an item into the chain.
// Depends on lgta_pkg.
module lgta_head #(
    parameter int SIGMA_CELLS = lgta_pkg::SIGMA_CELLS_DEF,
    parameter int TAU_CELLS   = lgta_pkg::TAU_CELLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  lgta_pkg::t_in_beat i_data,
    output lgta_pkg::t_item  o_item
);
    import lgta_pkg::*;

    logic [TIME_W-1:0] r_s_first, r_s_last, r_t_first, r_t_last;
    t_item             r_item;
    t_op               w_op;
    t_status           w_status;
    logic [TIME_W:0]   w_s_end, w_t_end;
    logic              w_inside;
    logic              w_accept;

    assign w_accept = i_valid && i_adv;

    always_comb begin
        w_s_end  = {1'b0, i_data.start_sigma} + {1'b0, i_data.duration};
        w_t_end  = {1'b0, i_data.start_tau} + {1'b0, i_data.duration};
        w_inside = (i_data.start_sigma >= r_s_first) && (i_data.start_sigma < r_s_last)
                && (i_data.start_tau >= r_t_first) && (i_data.start_tau < r_t_last)
                && (w_s_end >= {1'b0, r_s_first}) && (w_s_end < {1'b0, r_s_last})
                && (w_t_end >= {1'b0, r_t_first}) && (w_t_end < {1'b0, r_t_last});
        w_op     = OP_NOP;
        w_status = ST_RANGE;
        case (i_data.action)
            ACT_LOAD: begin
                if ((!i_data.axis && int'(i_data.edge_index) <= SIGMA_CELLS)
                        || (i_data.axis && int'(i_data.edge_index) <= TAU_CELLS)) begin
                    w_op     = OP_LOAD;
                    w_status = ST_OK;
                end
            end
            ACT_ADD: begin
                if (w_inside) begin
                    w_op     = OP_ADD;
                    w_status = ST_OK;
                end else begin
                    w_status = ST_OUTSIDE;
                end
            end
            ACT_READ: begin
                if (int'(i_data.cell_row) < SIGMA_CELLS && int'(i_data.cell_col) < TAU_CELLS) begin
                    w_op     = OP_READ;
                    w_status = ST_OK;
                end
            end
            default: begin
                w_op     = OP_NOP;
                w_status = ST_RANGE;
            end
        endcase
    end

    // Outer edge copies for the inside check; same updates as the cells see.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_first <= '0;
            r_s_last  <= '0;
            r_t_first <= '0;
            r_t_last  <= '0;
        end else if (w_accept && w_op == OP_LOAD) begin
            if (!i_data.axis) begin
                if (i_data.edge_index == 3'd0) r_s_first <= i_data.edge_value;
                if (int'(i_data.edge_index) == SIGMA_CELLS) r_s_last <= i_data.edge_value;
            end else begin
                if (i_data.edge_index == 3'd0) r_t_first <= i_data.edge_value;
                if (int'(i_data.edge_index) == TAU_CELLS) r_t_last <= i_data.edge_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_item.valid      <= i_valid;
            r_item.op         <= w_op;
            r_item.status     <= w_status;
            r_item.axis       <= i_data.axis;
            r_item.edge_index <= i_data.edge_index;
            r_item.edge_value <= i_data.edge_value;
            r_item.s          <= i_data.start_sigma;
            r_item.t          <= i_data.start_tau;
            r_item.d          <= i_data.duration;
            r_item.row        <= i_data.cell_row;
            r_item.col        <= i_data.cell_col;
            r_item.total      <= '0;
        end
    end

    assign o_item = r_item;

endmodule

@@ rtl/lgta_cell.sv @@
// One grid cell of the accumulator chain: holds its low and high edge on each axis and its total.
// Stage A clips the diagonal to the cell, stage B adds it or answers a read.
// Depends on lgta_pkg.
module lgta_cell #(
    parameter int ROW         = 0,
    parameter int COL         = 0,
    parameter int TOTAL_WIDTH = lgta_pkg::TOTAL_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  lgta_pkg::t_item i_item,
    output lgta_pkg::t_item o_item
);
    import lgta_pkg::*;

    logic [TIME_W-1:0]        r_s_lo, r_s_hi, r_t_lo, r_t_hi;
    logic [TOTAL_WIDTH-1:0]   r_total;
    t_item                    r_a, r_b;
    t_item                    n_b;
    logic signed [TIME_W:0]   r_hi, r_lo;

    logic signed [TIME_W:0]   w_sh, w_sl, w_th, w_tl, w_hi, w_lo, w_diff;
    logic                     w_gain, w_hit;
    logic [TOTAL_WIDTH:0]     w_sum;
    logic [TOTAL_WIDTH-1:0]   w_new;
    logic [OUT_W-1:0]         w_rd;

    // Edge loads take effect as the load passes, before the next item arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_lo <= '0;
            r_s_hi <= '0;
            r_t_lo <= '0;
            r_t_hi <= '0;
        end else if (i_adv && i_item.valid && i_item.op == OP_LOAD) begin
            if (!i_item.axis) begin
                if (int'(i_item.edge_index) == ROW)     r_s_lo <= i_item.edge_value;
                if (int'(i_item.edge_index) == ROW + 1) r_s_hi <= i_item.edge_value;
            end else begin
                if (int'(i_item.edge_index) == COL)     r_t_lo <= i_item.edge_value;
                if (int'(i_item.edge_index) == COL + 1) r_t_hi <= i_item.edge_value;
            end
        end
    end

    // Stage A: clip the diagonal to this cell's rectangle.
    always_comb begin
        w_sh = $signed({1'b0, r_s_hi}) - $signed({1'b0, i_item.s});
        w_th = $signed({1'b0, r_t_hi}) - $signed({1'b0, i_item.t});
        w_sl = $signed({1'b0, r_s_lo}) - $signed({1'b0, i_item.s});
        w_tl = $signed({1'b0, r_t_lo}) - $signed({1'b0, i_item.t});
        w_hi = $signed({1'b0, i_item.d});
        if (w_sh < w_hi) w_hi = w_sh;
        if (w_th < w_hi) w_hi = w_th;
        w_lo = '0;
        if (w_sl > w_lo) w_lo = w_sl;
        if (w_tl > w_lo) w_lo = w_tl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (i_adv) begin
            r_a  <= i_item;
            r_hi <= w_hi;
            r_lo <= w_lo;
        end
    end

    // Stage B: saturating accumulate, read capture.
    always_comb begin
        w_gain = r_hi > r_lo;
        w_diff = r_hi - r_lo;
        w_sum  = {1'b0, r_total} + (TOTAL_WIDTH + 1)'(w_diff[TIME_W-1:0]);
        w_new  = w_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : w_sum[TOTAL_WIDTH-1:0];
        w_hit  = r_a.valid && r_a.op == OP_READ
              && int'(r_a.row) == ROW && int'(r_a.col) == COL;
    end

    generate
        if (TOTAL_WIDTH > OUT_W) begin : g_rd_sat
            assign w_rd = (|r_total[TOTAL_WIDTH-1:OUT_W]) ? {OUT_W{1'b1}}
                                                           : r_total[OUT_W-1:0];
        end else begin : g_rd_ext
            assign w_rd = OUT_W'(r_total);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_adv && r_a.valid && r_a.op == OP_ADD && w_gain) begin
            r_total <= w_new;
        end
    end

    always_comb begin
        n_b = r_a;
        if (w_hit) n_b.total = w_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_adv) begin
            r_b <= n_b;
        end
    end

    assign o_item = r_b;

endmodule

@@ rtl/lexis_grid_time_accumulator.sv @@
// Each beat passes the entry stage register, then stage A and stage B of every cell in chain order.
// Throughput: one beat per cycle; the entry stage and every cell stage move
// together, and the whole chain holds while the result at its end waits.
// Reset (synchronous, active low) clears all edges, all cell totals and all
// stage valid flags.
// Top level; depends on lgta_pkg, lgta_head and lgta_cell.
module lexis_grid_time_accumulator #(
    parameter int SIGMA_CELLS = lgta_pkg::SIGMA_CELLS_DEF,
    parameter int TAU_CELLS   = lgta_pkg::TAU_CELLS_DEF,
    parameter int TOTAL_WIDTH = lgta_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  lgta_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output lgta_pkg::t_out_beat o_data
);
    import lgta_pkg::*;

    localparam int NumCells = SIGMA_CELLS * TAU_CELLS;

    t_item w_link [0:NumCells];
    logic  w_adv;

    // Advance whenever the last stage is empty or being drained.
    assign w_adv   = !w_link[NumCells].valid || i_ready;
    assign o_ready = w_adv;

    lgta_head #(
        .SIGMA_CELLS (SIGMA_CELLS),
        .TAU_CELLS   (TAU_CELLS)
    ) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_item  (w_link[0])
    );

    generate
        for (genvar gi = 0; gi < SIGMA_CELLS; gi++) begin : g_row
            for (genvar gj = 0; gj < TAU_CELLS; gj++) begin : g_col
                localparam int K = gi * TAU_CELLS + gj;
                lgta_cell #(
                    .ROW         (gi),
                    .COL         (gj),
                    .TOTAL_WIDTH (TOTAL_WIDTH)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_adv   (w_adv),
                    .i_item  (w_link[K]),
                    .o_item  (w_link[K+1])
                );
            end
        end
    endgenerate

    assign o_valid           = w_link[NumCells].valid;
    assign o_data.status     = w_link[NumCells].status;
    assign o_data.cell_total = w_link[NumCells].total;

endmodule

@@ rtl/lgta_checker.sv @@
// Port-level checks for the lexis grid time accumulator, bound to the top.
// Depends on lgta_pkg and lexis_grid_time_accumulator.
module lgta_port_checks (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input lgta_pkg::t_in_beat  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input lgta_pkg::t_out_beat o_data
);
    import lgta_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    // Input side opens exactly when the result slot is free or draining.
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output slot");

    // A beat with an error status never carries a total.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.cell_total == '0)
        else $error("nonzero total on error status");

    // Nothing comes out in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result beat right after reset");

endmodule

bind lexis_grid_time_accumulator lgta_port_checks u_lgta_checker (.*);

@@ tb/lgta_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the lexis grid time accumulator: watches the input and result
// channels, keeps its own edges and cell totals, and checks every result beat.
// Depends on lgta_pkg.
module lgta_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lgta_pkg::t_in_beat  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lgta_pkg::t_out_beat i_out_data,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_results
);
    import lgta_pkg::*;

    localparam int     NS         = SIGMA_CELLS_DEF;
    localparam int     NT         = TAU_CELLS_DEF;
    localparam longint SUM_MAX    = (longint'(1) << TOTAL_WIDTH_DEF) - 1;
    localparam longint OUT_MAX    = (longint'(1) << OUT_W) - 1;

    logic [TIME_W-1:0] sigma_edge [NS+1];
    logic [TIME_W-1:0] tau_edge   [NT+1];
    longint            cell_sum   [NS*NT];
    t_out_beat         expected_beats [$];

    function automatic bit on_grid(longint s, longint t);
        longint s0, sn, t0, tn;
        s0 = sigma_edge[0];
        sn = sigma_edge[NS];
        t0 = tau_edge[0];
        tn = tau_edge[NT];
        return (s0 <= s) && (s < sn) && (t0 <= t) && (t < tn);
    endfunction

    // Apply one input beat to the local grid and return the result it should give.
    task automatic grid_apply(input t_in_beat b, output t_out_beat r);
        longint s1, t1, dd, hi, lo, sl, sh, tl, th, len;
        int     i, j;
        r.status     = ST_OK;
        r.cell_total = '0;
        case (b.action)
            ACT_LOAD: begin
                if (b.axis == 1'b0) begin
                    if (b.edge_index <= NS) sigma_edge[b.edge_index] = b.edge_value;
                    else r.status = ST_RANGE;
                end else begin
                    if (b.edge_index <= NT) tau_edge[b.edge_index] = b.edge_value;
                    else r.status = ST_RANGE;
                end
            end
            ACT_ADD: begin
                s1 = b.start_sigma;
                t1 = b.start_tau;
                dd = b.duration;
                // the end point is taken without wrap, so it may pass 2^32
                if (!on_grid(s1, t1) || !on_grid(s1 + dd, t1 + dd)) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    for (i = 0; i < NS; i++) begin
                        for (j = 0; j < NT; j++) begin
                            sl = sigma_edge[i];
                            sh = sigma_edge[i+1];
                            tl = tau_edge[j];
                            th = tau_edge[j+1];
                            hi = dd;
                            if (sh - s1 < hi) hi = sh - s1;
                            if (th - t1 < hi) hi = th - t1;
                            lo = 0;
                            if (sl - s1 > lo) lo = sl - s1;
                            if (tl - t1 > lo) lo = tl - t1;
                            if (hi > lo) begin
                                len = hi - lo;
                                if (cell_sum[i*NT+j] > SUM_MAX - len)
                                    cell_sum[i*NT+j] = SUM_MAX;
                                else
                                    cell_sum[i*NT+j] = cell_sum[i*NT+j] + len;
                            end
                        end
                    end
                end
            end
            ACT_READ: begin
                if (b.cell_row < NS && b.cell_col < NT) begin
                    len = cell_sum[b.cell_row*NT + b.cell_col];
                    if (len > OUT_MAX) len = OUT_MAX;
                    r.cell_total = len[OUT_W-1:0];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
    endtask

    task automatic flag_field(input string field, input longint want, input longint got);
        o_mismatches++;
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            foreach (sigma_edge[k]) sigma_edge[k] = '0;
            foreach (tau_edge[k]) tau_edge[k] = '0;
            foreach (cell_sum[k]) cell_sum[k] = 0;
            expected_beats.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                grid_apply(i_in_data, want);
                expected_beats.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                o_results++;
                if (expected_beats.size() == 0) begin
                    o_mismatches++;
                    $error("result beat with nothing expected: status %0d, total %0h",
                           got.status, got.cell_total);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.status !== want.status)
                        flag_field("status", longint'(want.status), longint'(got.status));
                    if (got.cell_total !== want.cell_total)
                        flag_field("cell_total", longint'(want.cell_total),
                                   longint'(got.cell_total));
                end
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the lexis grid time accumulator testbench: clock, reset, stimulus and verdict.
// Depends on lgta_pkg, lexis_grid_time_accumulator and lgta_checker.
module tb_top;
    import lgta_pkg::*;

    localparam int     RANDOM_ITEMS = 680;
    localparam int     SOAK_ADDS    = 24;
    localparam int     SETTLE       = 40;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam longint T_MAX        = 64'h0000_0000_FFFF_FFFF;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    bit        steady = 1'b0;
    int        mismatches, pending, results;
    int        cycle_count = 0;
    int        n_load = 0, n_add = 0, n_read = 0, n_other = 0;
    logic [31:0] sigma_seen [5];
    logic [31:0] tau_seen   [5];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    lexis_grid_time_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    lgta_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    always @(negedge i_clk) begin
        i_ready <= i_rst_n && (steady || ($urandom_range(0, 99) >= 19));
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** lexis_grid_time_accumulator: FAILED **");
        $finish;
    end

    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b.action      = t_action'(2'($urandom));
        b.axis        = 1'($urandom);
        b.edge_index  = 3'($urandom);
        b.edge_value  = $urandom;
        b.start_sigma = $urandom;
        b.start_tau   = $urandom;
        b.duration    = $urandom;
        b.cell_row    = 2'($urandom);
        b.cell_col    = 2'($urandom);
        return b;
    endfunction

    function automatic t_in_beat load_beat(logic axis, logic [2:0] idx, logic [31:0] val);
        t_in_beat b;
        b            = noise_beat();
        b.action     = ACT_LOAD;
        b.axis       = axis;
        b.edge_index = idx;
        b.edge_value = val;
        return b;
    endfunction

    function automatic t_in_beat add_beat(logic [31:0] s, logic [31:0] t, logic [31:0] d);
        t_in_beat b;
        b             = noise_beat();
        b.action      = ACT_ADD;
        b.start_sigma = s;
        b.start_tau   = t;
        b.duration    = d;
        return b;
    endfunction

    function automatic t_in_beat read_beat(logic [1:0] row, logic [1:0] col);
        t_in_beat b;
        b          = noise_beat();
        b.action   = ACT_READ;
        b.cell_row = row;
        b.cell_col = col;
        return b;
    endfunction

    // Entered and left at a falling edge; holds the beat until it is taken.
    task automatic push_beat(input t_in_beat b);
        if (!steady) begin
            while ($urandom_range(0, 99) < 19) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        case (b.action)
            ACT_LOAD: begin
                n_load++;
                if (b.edge_index <= 4) begin
                    if (b.axis == 1'b0) sigma_seen[b.edge_index] = b.edge_value;
                    else tau_seen[b.edge_index] = b.edge_value;
                end
            end
            ACT_ADD:  n_add++;
            ACT_READ: n_read++;
            default:  n_other++;
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Load every sigma and tau edge of the grid in shuffled order.
    task automatic load_grid(input logic [31:0] gs [5], input logic [31:0] gt [5]);
        t_in_beat order [10];
        t_in_beat tmp;
        int       k, m;
        for (k = 0; k < 5; k++) begin
            order[k]   = load_beat(1'b0, 3'(k), gs[k]);
            order[k+5] = load_beat(1'b1, 3'(k), gt[k]);
        end
        for (k = 9; k > 0; k--) begin
            m        = $urandom_range(k, 0);
            tmp      = order[k];
            order[k] = order[m];
            order[m] = tmp;
        end
        for (k = 0; k < 10; k++) push_beat(order[k]);
    endtask

    // Strictly rising edges; cell widths from very narrow to a large part of the range.
    task automatic make_edges(output logic [31:0] e [5]);
        longint      v [5];
        longint      shift;
        int unsigned span;
        int          k;
        case ($urandom_range(0, 3))
            0:       span = 32'd15;
            1:       span = 32'h0000_FFFF;
            2:       span = 32'h003F_FFFF;
            default: span = 32'h1FFF_FFFF;
        endcase
        v[0] = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom);
        for (k = 1; k < 5; k++) v[k] = v[k-1] + 1 + longint'($urandom_range(span, 0));
        if (v[4] > T_MAX || $urandom_range(0, 7) == 0) begin
            shift = v[4] - T_MAX;
            for (k = 0; k < 5; k++) v[k] = v[k] - shift;
        end
        for (k = 0; k < 5; k++) e[k] = v[k][31:0];
    endtask

    // Segment starting inside the current grid, ending inside, on or past the edge; a random add on an empty grid.
    task automatic gen_add();
        longint   s0, sn, t0, tn, s, t, d, dmax;
        t_in_beat b;
        s0 = sigma_seen[0];
        sn = sigma_seen[4];
        t0 = tau_seen[0];
        tn = tau_seen[4];
        if (sn <= s0 || tn <= t0) begin
            b        = noise_beat();
            b.action = ACT_ADD;
            push_beat(b);
        end else begin
            if ($urandom_range(0, 3) == 0) s = sigma_seen[$urandom_range(0, 3)];
            else s = longint'($urandom_range(32'(sn - 1), 32'(s0)));
            if ($urandom_range(0, 3) == 0) t = tau_seen[$urandom_range(0, 3)];
            else t = longint'($urandom_range(32'(tn - 1), 32'(t0)));
            dmax = sn - 1 - s;
            if (tn - 1 - t < dmax) dmax = tn - 1 - t;
            if (dmax < 0) dmax = 0;
            case ($urandom_range(0, 15))
                0:       d = 0;
                1:       d = dmax;
                2:       d = (dmax + 1 > T_MAX) ? T_MAX : dmax + 1;
                3, 4, 5, 6, 7:
                         d = longint'($urandom_range(32'(dmax), 0));
                default: d = longint'($urandom_range(32'((dmax < 'h3FFFF) ? dmax : 'h3FFFF),
                                                     0));
            endcase
            push_beat(add_beat(32'(s), 32'(t), 32'(d)));
        end
    endtask

    initial begin : stimulus
        logic [31:0] gs [5];
        logic [31:0] gt [5];
        t_in_beat    b;
        int          k, m, p;

        foreach (sigma_seen[k]) sigma_seen[k] = '0;
        foreach (tau_seen[k]) tau_seen[k] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fresh grid: all edges zero, so totals read zero and every add lands outside.
        push_beat(read_beat(2'd0, 2'd0));
        push_beat(add_beat(32'd0, 32'd0, 32'd0));
        b        = noise_beat();
        b.action = t_action'(2'd3);
        push_beat(b);
        push_beat(load_beat(1'b0, 3'd5, $urandom));
        push_beat(load_beat(1'b1, 3'd7, 32'hFFFF_FFFF));

        gs = '{32'h0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'hFFFF_FFFF};
        gt = '{32'h0, 32'h0_8000, 32'h1_8000, 32'h4_0000, 32'hFFFF_FFFF};
        load_grid(gs, gt);
        push_beat(add_beat(32'h0, 32'h0, 32'h0));
        push_beat(add_beat(32'h0, 32'h0, 32'h5_0000));
        push_beat(add_beat(32'h1_0000, 32'h0_8000, 32'h1_0000));
        push_beat(add_beat(32'h0, 32'h0, 32'hFFFF_FFFE));
        push_beat(add_beat(32'h1, 32'h0, 32'hFFFF_FFFE));
        push_beat(add_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        push_beat(read_beat(2'd0, 2'd0));
        push_beat(read_beat(2'd3, 2'd3));
        // Edges out of order: the same clipping still applies to every cell.
        push_beat(load_beat(1'b0, 3'd2, 32'h0000_5000));
        push_beat(add_beat(32'h0, 32'h0, 32'h3_0000));
        push_beat(read_beat(2'd1, 2'd0));
        push_beat(read_beat(2'd0, 2'd1));

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 300) steady <= 1'b1;
            if (k == 480) steady <= 1'b0;
            if (k % 70 == 0) begin
                make_edges(gs);
                make_edges(gt);
                if ($urandom_range(0, 5) == 0) begin
                    for (m = 0; m < 5; m++) begin
                        gs[m] = $urandom;
                        gt[m] = $urandom;
                    end
                end
                load_grid(gs, gt);
            end
            if (k % 97 == 50) wait_drained();
            p = $urandom_range(0, 99);
            if (p < 55) begin
                gen_add();
            end else if (p < 75) begin
                push_beat(read_beat(2'($urandom), 2'($urandom)));
            end else if (p < 83) begin
                b        = noise_beat();
                b.action = ACT_ADD;
                push_beat(b);
            end else if (p < 88) begin
                b        = noise_beat();
                b.action = t_action'(2'd3);
                push_beat(b);
            end else if (p < 93) begin
                push_beat(load_beat(1'($urandom), 3'($urandom_range(7, 5)), $urandom));
            end else if (p < 97) begin
                push_beat(load_beat(1'($urandom), 3'($urandom_range(4, 0)), $urandom));
            end else begin
                push_beat(noise_beat());
            end
        end

        // Pile large totals into one cell with back-to-back near-full-range segments.
        gs = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
        load_grid(gs, gs);
        steady <= 1'b1;
        for (k = 0; k < SOAK_ADDS; k++) push_beat(add_beat(32'd3, 32'd3, 32'hFFFF_FFFB));
        for (k = 0; k < 16; k++) push_beat(read_beat(2'(k / 4), 2'(k % 4)));
        steady <= 1'b0;

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Covered %0d edge loads, %0d segment adds, %0d cell reads, %0d unknown beats,",
                 n_load, n_add, n_read, n_other);
        $display("with random and out-of-order grids and a burst of large segments; %0d checked.",
                 results);
        if (mismatches == 0)
            $display("** lexis_grid_time_accumulator: PASSED **");
        else
            $display("** lexis_grid_time_accumulator: FAILED **");
        $finish;
    end

endmodule
